/* sv/plt_pkg.sv */
// Package with the shared types and constants of the positional list table engine.
package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = POS_W + 1;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 144;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_DISPLAY = 3'd4
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CM_HOLD   = 3'd0,
        CM_INSERT = 3'd1,
        CM_DELETE = 3'd2,
        CM_UPDATE = 3'd3,
        CM_ROTATE = 3'd4
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t                mode;
        logic [IDX_W-1:0]          slot;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        logic clear;
        logic en;
        logic first;
    } scan_ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] maximum;
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] total;
        logic                     found;
        logic [POS_W-1:0]         fpos;
    } scan_res_t;

endpackage

/* sv/plt_cell.sv */
// One storage cell of the element ring, loading from its neighbors or the command value.
module plt_cell (
    input  logic                               clk,
    input  plt_pkg::cell_cmd_t                 cmd,
    input  logic [plt_pkg::IDX_W-1:0]          idx,
    input  logic signed [plt_pkg::DATA_W-1:0]  left,
    input  logic signed [plt_pkg::DATA_W-1:0]  right,
    output logic signed [plt_pkg::DATA_W-1:0]  data
);
    import plt_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.mode)
            CM_HOLD:
            begin
                data_next = data_reg;
            end
            CM_INSERT:
            begin
                if (idx == cmd.slot)
                begin
                    data_next = cmd.value;
                end
                else if (idx > cmd.slot)
                begin
                    data_next = left;
                end
            end
            CM_DELETE:
            begin
                if (idx >= cmd.slot)
                begin
                    data_next = right;
                end
            end
            CM_UPDATE:
            begin
                if (idx == cmd.slot)
                begin
                    data_next = cmd.value;
                end
            end
            CM_ROTATE:
            begin
                data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* sv/plt_scan.sv */
// Accumulator that gathers maximum, minimum, sum and first match as elements pass the ring head.
module plt_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  plt_pkg::scan_ctl_t                 ctl,
    input  logic [plt_pkg::IDX_W-1:0]          idx,
    input  logic signed [plt_pkg::DATA_W-1:0]  elem,
    input  logic signed [plt_pkg::DATA_W-1:0]  key,
    output plt_pkg::scan_res_t                 res
);
    import plt_pkg::*;

    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] sum_reg, sum_next;
    logic                     found_reg, found_next;
    logic [POS_W-1:0]         fpos_reg, fpos_next;

    always_comb
    begin
        max_next   = max_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        found_next = found_reg;
        fpos_next  = fpos_reg;
        if (ctl.clear)
        begin
            max_next   = '0;
            min_next   = '0;
            sum_next   = '0;
            found_next = 1'b0;
            fpos_next  = '0;
        end
        else if (ctl.en)
        begin
            sum_next = sum_reg + elem;
            if (ctl.first || elem > max_reg)
            begin
                max_next = elem;
            end
            if (ctl.first || elem < min_reg)
            begin
                min_next = elem;
            end
            if (!found_reg && elem == key)
            begin
                found_next = 1'b1;
                fpos_next  = POS_W'(idx) + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg  <= max_next;
        min_reg  <= min_next;
        sum_reg  <= sum_next;
        fpos_reg <= fpos_next;
    end

    assign res.maximum = max_reg;
    assign res.minimum = min_reg;
    assign res.total   = sum_reg;
    assign res.found   = found_reg;
    assign res.fpos    = fpos_reg;

endmodule

/* sv/positional_list_table_engine.sv */
// Top level of the positional list table engine: cell ring, command decode and result register.
//
// The list lives in a ring of CAPACITY cells, position 1 in cell 0. An insert, delete or
// update changes the cells in the cycle the item is accepted; an insert or delete shifts
// the cells from that position on by one step at once. The ring then rotates one full turn
// so that each element passes cell 0, where maximum, minimum, sum and the search match are
// gathered; the result is then loaded into the output register once the output side does
// not stall. A display of a non-empty list instead rotates the ring a second time and gives
// one result per element, holding the ring while the output side stalls. A new item is
// taken only when the previous one is finished, but a result may still be waiting in the
// output register.
module positional_list_table_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plt_pkg::S_DATA_W-1:0]  s_tdata,  // position[6:0], value[38:7], zeros
    input  logic [plt_pkg::OP_W-1:0]      s_tuser,  // opcode[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plt_pkg::M_DATA_W-1:0]  m_tdata,  // found_position[6:0], element[38:7],
                                                    // count[45:39], maximum[77:46],
                                                    // minimum[109:78], total[141:110], zeros
    output logic [plt_pkg::ST_W-1:0]      m_tuser,  // status[2:0]
    output logic                          m_tlast
);
    import plt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_SHOW = 4'b1000
    } state_t;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         fpos;
        logic signed [DATA_W-1:0] element;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] maximum;
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] total;
        logic                     last;
    } out_item_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    opcode_t                  op_reg, op_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     ovalid_reg, ovalid_next;
    out_item_t                out_reg, out_next;

    logic [POS_W-1:0]         in_pos;
    logic signed [DATA_W-1:0] in_value;
    opcode_t                  in_op;
    logic                     accept;
    logic                     out_busy;
    logic                     ins_ok;
    logic                     pos_ok;
    logic                     step_in;
    logic                     step_end;

    cell_cmd_t                cmd;
    scan_ctl_t                sctl;
    scan_res_t                sres;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+DATA_W-1:POS_W];
    assign in_op    = opcode_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_busy = ovalid_reg && !m_tready;

    assign ins_ok   = (in_pos != '0) &&
                      ({1'b0, in_pos} <= CMP_W'(count_reg) + CMP_W'(1));
    assign pos_ok   = (in_pos != '0) && ({1'b0, in_pos} <= CMP_W'(count_reg));
    assign step_in  = CNT_W'(step_reg) < count_reg;
    assign step_end = (step_reg == IDX_W'(CAPACITY - 1));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            plt_cell u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .idx   (IDX_W'(gi)),
                .left  (cell_data[(gi + CAPACITY - 1) % CAPACITY]),
                .right (cell_data[(gi + 1) % CAPACITY]),
                .data  (cell_data[gi])
            );
        end
    endgenerate

    plt_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sctl),
        .idx   (step_reg),
        .elem  (cell_data[0]),
        .key   (key_reg),
        .res   (sres)
    );

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        status_next = status_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg;
        out_next    = out_reg;
        cmd.mode    = CM_HOLD;
        cmd.slot    = IDX_W'(in_pos - POS_W'(1));
        cmd.value   = in_value;
        sctl.clear  = 1'b0;
        sctl.en     = 1'b0;
        sctl.first  = (step_reg == '0);

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    key_next    = in_value;
                    step_next   = '0;
                    sctl.clear  = 1'b1;
                    state_next  = S_SCAN;
                    status_next = ST_OK;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (!ins_ok)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.mode   = CM_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE, OP_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (in_op == OP_DELETE)
                            begin
                                cmd.mode   = CM_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                cmd.mode = CM_UPDATE;
                            end
                        end
                        OP_SEARCH, OP_DISPLAY:
                        begin
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            status_next = ST_BAD_POS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.mode  = CM_ROTATE;
                sctl.en   = step_in;
                step_next = step_reg + IDX_W'(1);
                if (step_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    if (op_reg == OP_DISPLAY && count_reg != '0)
                    begin
                        state_next = S_SHOW;
                        step_next  = '0;
                    end
                    else
                    begin
                        state_next       = S_IDLE;
                        ovalid_next      = 1'b1;
                        out_next.status  = status_reg;
                        out_next.fpos    = '0;
                        out_next.element = '0;
                        out_next.count   = count_reg;
                        out_next.maximum = sres.maximum;
                        out_next.minimum = sres.minimum;
                        out_next.total   = sres.total;
                        out_next.last    = 1'b1;
                        if (op_reg == OP_DISPLAY)
                        begin
                            out_next.status = ST_EMPTY;
                        end
                        else if (op_reg == OP_SEARCH)
                        begin
                            out_next.status = sres.found ? ST_OK : ST_NOT_FOUND;
                            out_next.fpos   = sres.found ? sres.fpos : '0;
                        end
                    end
                end
            end
            S_SHOW:
            begin
                if (!step_in || !out_busy)
                begin
                    cmd.mode  = CM_ROTATE;
                    step_next = step_reg + IDX_W'(1);
                    if (step_in)
                    begin
                        ovalid_next      = 1'b1;
                        out_next.status  = ST_OK;
                        out_next.fpos    = POS_W'(step_reg) + POS_W'(1);
                        out_next.element = cell_data[0];
                        out_next.count   = count_reg;
                        out_next.maximum = sres.maximum;
                        out_next.minimum = sres.minimum;
                        out_next.total   = sres.total;
                        out_next.last    = (CNT_W'(step_reg) + CNT_W'(1) == count_reg);
                    end
                    if (step_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            op_reg     <= OP_INSERT;
            status_reg <= ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            op_reg     <= op_next;
            status_reg <= status_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_reg.total, out_reg.minimum, out_reg.maximum,
                       POS_W'(out_reg.count), out_reg.element, out_reg.fpos};

endmodule
